@@ rtl/gjinv_pkg.sv @@
// Shared constants and helper functions of the Gauss-Jordan matrix inverse block.
package gjinv_pkg;

  localparam int unsigned MAX_ORDER_DEF   = 8;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned ORDER_W   = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  // The register index is the word address, which is paddr[2] here.
  localparam logic REG_MATRIX_ORDER = 1'b0;

  // Working width of the arithmetic: the value width limited to 2..32 bits.
  function automatic int unsigned eff_w(input int unsigned vw);
    int unsigned w;
    w = vw;
    if (w > 32) w = 32;
    if (w < 2) w = 2;
    return w;
  endfunction

  function automatic int unsigned idx_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ rtl/gjinv_queue.sv @@
// Two-entry request queue between the loader and the elimination engine.
module gjinv_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ rtl/gjinv_front.sv @@
// Loader: accepts elements, clips them, tags them with their index and the end of a matrix.
module gjinv_front #(
  parameter int unsigned MAX_ORDER   = gjinv_pkg::MAX_ORDER_DEF,
  parameter int unsigned VALUE_WIDTH = gjinv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [gjinv_pkg::ELEM_W-1:0]    element_value_i,
  input  logic [gjinv_pkg::ORDER_W-1:0]          order_i,
  input  logic                                   full_i,
  output logic                                   push_o,
  output logic [gjinv_pkg::eff_w(VALUE_WIDTH) +
                gjinv_pkg::idx_w(MAX_ORDER*MAX_ORDER) +
                $clog2(MAX_ORDER+1) + 1:0]       data_o
);

  localparam int unsigned EW    = gjinv_pkg::eff_w(VALUE_WIDTH);
  localparam int unsigned NW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned CELLS = MAX_ORDER * MAX_ORDER;
  localparam int unsigned IW    = gjinv_pkg::idx_w(CELLS);
  localparam int unsigned LCW   = $clog2(CELLS + 1);
  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (EW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

  logic [LCW-1:0]    load_cnt_q, load_cnt_d;
  logic [NW-1:0]     n_eff;
  logic [LCW-1:0]    total;
  logic [LCW:0]      cnt_inc;
  logic              last;
  logic signed [63:0] v64;
  logic [EW-1:0]     val;
  logic              clipped;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    if (order_i == '0) begin
      n_eff = NW'(1);
    end else if (order_i > gjinv_pkg::ORDER_W'(MAX_ORDER)) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(order_i);
    end
    total   = LCW'(n_eff) * LCW'(n_eff);
    cnt_inc = (LCW+1)'(load_cnt_q) + (LCW+1)'(1);
    last    = (cnt_inc >= (LCW+1)'(total));
    load_cnt_d = last ? '0 : LCW'(cnt_inc);

    v64 = 64'(element_value_i);
    if (v64 > VMAX64) begin
      val = VMAX64[EW-1:0];
      clipped = 1'b1;
    end else if (v64 < VMIN64) begin
      val = VMIN64[EW-1:0];
      clipped = 1'b1;
    end else begin
      val = v64[EW-1:0];
      clipped = 1'b0;
    end
  end

  assign data_o = {clipped, val, load_cnt_q[IW-1:0], last, n_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (push_o) begin
      load_cnt_q <= load_cnt_d;
    end
  end

endmodule

@@ rtl/gjinv_div.sv @@
// Bit-serial rounding divider: round((x * 2^16) / p) with saturation, one bit per cycle.
module gjinv_div #(
  parameter int unsigned EW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [EW-1:0] dividend_i,
  input  logic signed [EW-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [EW-1:0]        quotient_o,
  output logic                 clip_o
);

  localparam int unsigned DW = 2 * EW + 18;
  localparam int unsigned CNT_W = $clog2(EW + 1);
  localparam logic [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};

  logic [DW-1:0]    rem_q, dsh_q;
  logic [EW-1:0]    quo_q;
  logic             neg_q, ovf_q, busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [EW-1:0]    num_mag, den_mag;
  logic [DW-1:0]    dvd_w, dvs_w;
  logic             over;

  always_comb begin
    num_mag = dividend_i[EW-1] ? (~dividend_i + EW'(1)) : dividend_i;
    den_mag = divisor_i[EW-1] ? (~divisor_i + EW'(1)) : divisor_i;
    dvd_w   = (DW'(num_mag) << 17) + DW'(den_mag);
    dvs_w   = DW'(den_mag) << 1;
    over    = (quo_q[EW-1] && (!neg_q || (quo_q[EW-2:0] != '0))) || ovf_q;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign clip_o     = over;
  assign quotient_o = over ? (neg_q ? VMIN : VMAX) : (neg_q ? (~quo_q + EW'(1)) : quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(EW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dvd_w;
      dsh_q <= dvs_w << (EW - 1);
      quo_q <= '0;
      neg_q <= dividend_i[EW-1] ^ divisor_i[EW-1];
      ovf_q <= (dvd_w >= (dvs_w << EW));
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[EW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[EW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

endmodule

@@ rtl/gjinv_engine.sv @@
// Elimination engine: stores the matrix, runs Gauss-Jordan elimination and emits the inverse.
module gjinv_engine #(
  parameter int unsigned MAX_ORDER   = gjinv_pkg::MAX_ORDER_DEF,
  parameter int unsigned VALUE_WIDTH = gjinv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  input  logic [gjinv_pkg::eff_w(VALUE_WIDTH) +
                gjinv_pkg::idx_w(MAX_ORDER*MAX_ORDER) +
                $clog2(MAX_ORDER+1) + 1:0]       data_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [gjinv_pkg::OUT_IDX_W-1:0]        out_row_o,
  output logic [gjinv_pkg::OUT_IDX_W-1:0]        out_col_o,
  output logic signed [gjinv_pkg::ELEM_W-1:0]    inverse_value_o,
  output logic                                   singular_o,
  output logic                                   saturated_o,
  output logic                                   last_of_run_o
);

  localparam int unsigned EW    = gjinv_pkg::eff_w(VALUE_WIDTH);
  localparam int unsigned NW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned CW    = gjinv_pkg::idx_w(MAX_ORDER);
  localparam int unsigned CELLS = MAX_ORDER * MAX_ORDER;
  localparam int unsigned IW    = gjinv_pkg::idx_w(CELLS);
  localparam int unsigned AFW   = IW + NW + CW;
  localparam int unsigned MW    = 2 * EW;
  localparam logic [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic          ONE_CLIP = (EW <= 17);
  localparam logic [EW-1:0] ONE_V = ONE_CLIP ? VMAX : EW'(65536);

  typedef enum logic [18:0] {
    ST_IDLE      = 19'h00001,
    ST_INIT      = 19'h00002,
    ST_INIT_TAIL = 19'h00004,
    ST_PIV_RD    = 19'h00008,
    ST_PIV_CAP   = 19'h00010,
    ST_DIV_RD    = 19'h00020,
    ST_DIV_W     = 19'h00040,
    ST_DIV_WW    = 19'h00080,
    ST_DIV_IW    = 19'h00100,
    ST_ROW_CHK   = 19'h00200,
    ST_Q_RD      = 19'h00400,
    ST_Q_CAP     = 19'h00800,
    ST_MRK       = 19'h01000,
    ST_MRI       = 19'h02000,
    ST_M1        = 19'h04000,
    ST_M2        = 19'h08000,
    ST_M3        = 19'h10000,
    ST_EMIT_RD   = 19'h20000,
    ST_EMIT_LD   = 19'h40000
  } state_e;

  state_e state_q, state_d;

  // Request fields from the queue.
  logic          rq_clip, rq_last;
  logic [EW-1:0] rq_val;
  logic [IW-1:0] rq_idx;
  logic [NW-1:0] rq_n;

  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [NW-1:0] n_q, n_d;
  logic          sat_q, sat_d, sing_q, sing_d, init_v_q;
  logic [EW-1:0] piv_q, fac_q, wk_q, ik_q, wi_q, ii_q;
  logic [MW-1:0] prod_q;
  logic          pneg_q;

  logic [EW:0]   work_mem [CELLS];
  logic [EW-1:0] inv_mem  [CELLS];
  logic [EW:0]   work_rd_q;
  logic [EW-1:0] inv_rd_q;
  logic [IW-1:0] rd_addr, work_wa, inv_wa;
  logic [EW:0]   work_wd;
  logic [EW-1:0] inv_wd;
  logic          work_we, inv_we;

  logic [CW-1:0] nm1;
  logic          i_last, j_last, k_last;
  logic [IW-1:0] a_ij, a_kj, a_kk, a_ik;

  logic          div_start, div_busy, div_done, div_clip;
  logic [EW-1:0] div_x, div_val;

  logic [EW:0]   mul_res, sub_res;
  logic [EW-1:0] prod_op;

  logic          out_valid_q, out_valid_d, out_load;
  logic [gjinv_pkg::OUT_IDX_W-1:0] out_row_q, out_col_q;
  logic [EW-1:0] out_val_q;
  logic          out_sing_q, out_sat_q, out_last_q;

  function automatic logic [IW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                            input logic [NW-1:0] n);
    logic [AFW-1:0] full;
    full = AFW'(r) * AFW'(n) + AFW'(c);
    return full[IW-1:0];
  endfunction

  function automatic logic [EW-1:0] mag(input logic [EW-1:0] x);
    return x[EW-1] ? (~x + EW'(1)) : x;
  endfunction

  // Rounds a Q32.32 magnitude back to Q16.16 and saturates; returns {clip, value}.
  function automatic logic [EW:0] mul_sat(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0] r, lim;
    logic [EW-1:0] v;
    r   = (m + MW'(32768)) >> 16;
    lim = neg ? MW'(VMIN) : MW'(VMAX);
    v   = r[EW-1:0];
    if (r > lim) begin
      return {1'b1, (neg ? VMIN : VMAX)};
    end
    return {1'b0, (neg ? (~v + EW'(1)) : v)};
  endfunction

  function automatic logic [EW:0] sub_sat(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [EW:0] d;
    d = {a[EW-1], a} - {b[EW-1], b};
    if (d[EW] != d[EW-1]) begin
      return {1'b1, (d[EW] ? VMIN : VMAX)};
    end
    return {1'b0, d[EW-1:0]};
  endfunction

  assign {rq_clip, rq_val, rq_idx, rq_last, rq_n} = data_i;

  assign nm1    = CW'(n_q - NW'(1));
  assign i_last = (i_q == nm1);
  assign j_last = (j_q == nm1);
  assign k_last = (k_q == nm1);
  assign a_ij   = addr_of(i_q, j_q, n_q);
  assign a_kj   = addr_of(k_q, j_q, n_q);
  assign a_kk   = addr_of(k_q, k_q, n_q);
  assign a_ik   = addr_of(i_q, k_q, n_q);

  assign div_x   = (state_q == ST_DIV_W) ? work_rd_q[EW-1:0] : ik_q;
  assign prod_op = (state_q == ST_M1) ? wk_q : ik_q;
  assign mul_res = mul_sat(prod_q, pneg_q);
  assign sub_res = sub_sat((state_q == ST_M2) ? wi_q : ii_q, mul_res[EW-1:0]);

  gjinv_div #(
    .EW(EW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_x),
    .divisor_i  (piv_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_val),
    .clip_o     (div_clip)
  );

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    n_d         = n_q;
    sat_d       = sat_q;
    sing_d      = sing_q;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    work_we     = 1'b0;
    inv_we      = 1'b0;
    work_wa     = a_ij;
    inv_wa      = a_ij;
    work_wd     = {1'b0, sub_res[EW-1:0]};
    inv_wd      = sub_res[EW-1:0];
    rd_addr     = a_ij;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          work_we = 1'b1;
          work_wa = rq_idx;
          work_wd = {rq_clip, rq_val};
          if (rq_last) begin
            n_d     = rq_n;
            i_d     = '0;
            j_d     = '0;
            sat_d   = 1'b0;
            sing_d  = 1'b0;
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // Sweep: set the identity and collect the load clip marks of this matrix.
        inv_we = 1'b1;
        inv_wd = (i_q == j_q) ? ONE_V : '0;
        if (init_v_q) sat_d = sat_q | work_rd_q[EW];
        if (j_last) begin
          j_d = '0;
          if (i_last) begin
            state_d = ST_INIT_TAIL;
          end else begin
            i_d = i_q + CW'(1);
          end
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      ST_INIT_TAIL: begin
        sat_d   = sat_q | work_rd_q[EW] | ONE_CLIP;
        i_d     = '0;
        j_d     = '0;
        k_d     = '0;
        state_d = ST_PIV_RD;
      end
      ST_PIV_RD: begin
        rd_addr = a_kk;
        state_d = ST_PIV_CAP;
      end
      ST_PIV_CAP: begin
        j_d = '0;
        if (work_rd_q[EW-1:0] == '0) begin
          sing_d  = 1'b1;
          i_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_DIV_RD;
        end
      end
      ST_DIV_RD: begin
        rd_addr = a_kj;
        state_d = ST_DIV_W;
      end
      ST_DIV_W: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WW;
      end
      ST_DIV_WW: begin
        if (div_done) begin
          work_we   = 1'b1;
          work_wa   = a_kj;
          work_wd   = {1'b0, div_val};
          sat_d     = sat_q | div_clip;
          div_start = 1'b1;
          state_d   = ST_DIV_IW;
        end
      end
      ST_DIV_IW: begin
        if (div_done) begin
          inv_we = 1'b1;
          inv_wa = a_kj;
          inv_wd = div_val;
          sat_d  = sat_q | div_clip;
          if (j_last) begin
            j_d     = '0;
            i_d     = '0;
            state_d = ST_ROW_CHK;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = ST_DIV_RD;
          end
        end
      end
      ST_ROW_CHK: begin
        if (i_q != k_q) begin
          state_d = ST_Q_RD;
        end else if (!i_last) begin
          i_d = i_q + CW'(1);
        end else if (k_last) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ST_PIV_RD;
        end
      end
      ST_Q_RD: begin
        rd_addr = a_ik;
        state_d = ST_Q_CAP;
      end
      ST_Q_CAP: begin
        j_d     = '0;
        state_d = ST_MRK;
      end
      ST_MRK: begin
        rd_addr = a_kj;
        state_d = ST_MRI;
      end
      ST_MRI: begin
        rd_addr = a_ij;
        state_d = ST_M1;
      end
      ST_M1: begin
        state_d = ST_M2;
      end
      ST_M2: begin
        work_we = 1'b1;
        sat_d   = sat_q | mul_res[EW] | sub_res[EW];
        state_d = ST_M3;
      end
      ST_M3: begin
        inv_we = 1'b1;
        sat_d  = sat_q | mul_res[EW] | sub_res[EW];
        if (!j_last) begin
          j_d     = j_q + CW'(1);
          state_d = ST_MRK;
        end else begin
          j_d = '0;
          if (!i_last) begin
            i_d     = i_q + CW'(1);
            state_d = ST_ROW_CHK;
          end else if (k_last) begin
            i_d     = '0;
            state_d = ST_EMIT_RD;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = ST_PIV_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end else begin
              i_d     = i_q + CW'(1);
              state_d = ST_EMIT_RD;
            end
          end else begin
            j_d     = j_q + CW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      n_q         <= NW'(MAX_ORDER);
      sat_q       <= 1'b0;
      sing_q      <= 1'b0;
      init_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      n_q         <= n_d;
      sat_q       <= sat_d;
      sing_q      <= sing_d;
      init_v_q    <= (state_q == ST_INIT);
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PIV_CAP) piv_q <= work_rd_q[EW-1:0];
    if (state_q == ST_Q_CAP) fac_q <= work_rd_q[EW-1:0];
    if (state_q == ST_DIV_W) ik_q <= inv_rd_q;
    if (state_q == ST_MRI) begin
      wk_q <= work_rd_q[EW-1:0];
      ik_q <= inv_rd_q;
    end
    if (state_q == ST_M1) begin
      wi_q <= work_rd_q[EW-1:0];
      ii_q <= inv_rd_q;
    end
    if ((state_q == ST_M1) || (state_q == ST_M2)) begin
      prod_q <= MW'(mag(fac_q)) * MW'(mag(prod_op));
      pneg_q <= fac_q[EW-1] ^ prod_op[EW-1];
    end
    if (out_load) begin
      out_row_q  <= gjinv_pkg::OUT_IDX_W'(i_q);
      out_col_q  <= gjinv_pkg::OUT_IDX_W'(j_q);
      out_val_q  <= sing_q ? '0 : inv_rd_q;
      out_sing_q <= sing_q;
      out_sat_q  <= sat_q;
      out_last_q <= i_last && j_last;
    end
  end

  // Matrix storage: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    work_rd_q <= work_mem[rd_addr];
    inv_rd_q  <= inv_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign inverse_value_o = gjinv_pkg::ELEM_W'(signed'(out_val_q));
  assign singular_o      = out_sing_q;
  assign saturated_o     = out_sat_q;
  assign last_of_run_o   = out_last_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_sing_q |-> out_val_q == '0)
    else $error("singular result carries a nonzero value");

  a_no_pivot_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_M2 |-> i_q != k_q)
    else $error("elimination touched the pivot row");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE && !empty_i)
    else $error("queue popped outside the load phase");

endmodule

@@ rtl/gauss_jordan_matrix_inverse.sv @@
// Top level of the Gauss-Jordan matrix inverse block with its configuration register.
//
// Usage: write matrix_order (1..8) over the APB-style port at byte address 0 while
// the block is idle, then send the n*n matrix elements in row-major order on the
// input channel, one signed Q16.16 element per request. Each request is accepted
// when in_valid_i and in_ready_o are both high. A loader tags every element with
// its index and stores it through a two-entry queue, so elements are taken one per
// cycle while the engine is free and up to two more while it is busy.
// After the last element the engine inverts the matrix without pivoting. It sets
// up the identity, then for each pivot divides the pivot row with a bit-serial
// divider and removes the pivot column from the other rows with one shared
// multiplier. Results then leave as n*n requests, row-major, with row, column,
// singular, saturated and last-of-run marks. A zero pivot ends the run early and
// all its values are zero. When the receiver stalls, the result is held in the
// output register and the engine waits; meanwhile the queue takes at most two
// elements of the next matrix. Reset empties the queue, clears the load count and
// sets matrix_order to 8.
module gauss_jordan_matrix_inverse #(
  parameter int unsigned MAX_ORDER   = gjinv_pkg::MAX_ORDER_DEF,
  parameter int unsigned VALUE_WIDTH = gjinv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gjinv_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [gjinv_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [gjinv_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [gjinv_pkg::ELEM_W-1:0]   element_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gjinv_pkg::OUT_IDX_W-1:0]       out_row_o,
  output logic [gjinv_pkg::OUT_IDX_W-1:0]       out_col_o,
  output logic signed [gjinv_pkg::ELEM_W-1:0]   inverse_value_o,
  output logic                                  singular_o,
  output logic                                  saturated_o,
  output logic                                  last_of_run_o
);

  localparam int unsigned EW    = gjinv_pkg::eff_w(VALUE_WIDTH);
  localparam int unsigned NW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned IW    = gjinv_pkg::idx_w(MAX_ORDER * MAX_ORDER);
  localparam int unsigned ENT_W = EW + IW + NW + 2;

  logic [gjinv_pkg::ORDER_W-1:0] order_q;
  logic                          reg_sel;
  logic [ENT_W-1:0]              push_data, pop_data;
  logic                          push, pop, q_full, q_empty;

  // Configuration register; the word address selects the register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == gjinv_pkg::REG_MATRIX_ORDER);
  assign prdata  = reg_sel ? gjinv_pkg::APB_DATA_W'(order_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= gjinv_pkg::ORDER_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      order_q <= pwdata[gjinv_pkg::ORDER_W-1:0];
    end
  end

  gjinv_front #(
    .MAX_ORDER   (MAX_ORDER),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .order_i         (order_q),
    .full_i          (q_full),
    .push_o          (push),
    .data_o          (push_data)
  );

  gjinv_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gjinv_engine #(
    .MAX_ORDER   (MAX_ORDER),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .data_i          (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .inverse_value_o (inverse_value_o),
    .singular_o      (singular_o),
    .saturated_o     (saturated_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
